// File: hdl/glsg_pkg.sv
// ----------------------------------------------------------------------------
// glsg_pkg
// Shared types, constants and helper functions of the grid line step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package glsg_pkg;

  // Width of one signed span field (dx, dy).
  localparam int SPAN_W = 7;
  // Largest span magnitude; larger inputs are saturated to it.
  localparam int MAX_SPAN = 32;
  // Width of the step counter, holds up to 2 * MAX_SPAN.
  localparam int CNT_W = 7;
  // Width of the midpoint test accumulators; covers MAX_SPAN * (4 * MAX_SPAN + 1).
  localparam int ACC_W = 16;
  // Width of one signed step field.
  localparam int STEP_W = 2;

  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
  localparam logic signed [STEP_W-1:0] STEP_POS  = 2'sb01;
  localparam logic signed [STEP_W-1:0] STEP_NEG  = 2'sb11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new move from the input transfer
    logic step;  // compute one step into the output register
  } glsg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_zero;  // no step is left in the current move
    logic steps_last;  // exactly one step is left
    logic out_free;    // the output register can take a step this cycle
  } glsg_status_t;

  // Clamp a span to -MAX_SPAN..MAX_SPAN.
  function automatic logic signed [SPAN_W-1:0] sat_span(input logic signed [SPAN_W-1:0] v);
    logic signed [SPAN_W-1:0] r;
    if (v > MAX_SPAN) begin
      r = SPAN_W'(MAX_SPAN);
    end else if (v < -MAX_SPAN) begin
      r = SPAN_W'(-MAX_SPAN);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Magnitude of an already saturated span.
  function automatic logic [CNT_W-1:0] abs_span(input logic signed [SPAN_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v[SPAN_W-1]) begin
      r = CNT_W'(-v);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/glsg_ctrl.sv
// ----------------------------------------------------------------------------
// glsg_ctrl
// Sequencer: takes a move, runs a set-up state, then issues one step per
// cycle whenever the output register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module glsg_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire glsg_pkg::glsg_status_t status_i,
  output glsg_pkg::glsg_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status_i.steps_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.steps_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/glsg_datapath.sv
// ----------------------------------------------------------------------------
// glsg_datapath
// Move registers, step counter, incremental midpoint test and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module glsg_datapath (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire glsg_pkg::glsg_cmd_t                  cmd_i,
  output glsg_pkg::glsg_status_t                     status_o,
  input  wire logic signed [glsg_pkg::SPAN_W-1:0]   dx_i,
  input  wire logic signed [glsg_pkg::SPAN_W-1:0]   dy_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic signed [glsg_pkg::STEP_W-1:0]        step_x_o,
  output logic signed [glsg_pkg::STEP_W-1:0]        step_y_o,
  output logic                                      last_step_o
);

  localparam int SW = glsg_pkg::SPAN_W;
  localparam int AW = glsg_pkg::ACC_W;

  logic signed [SW-1:0] tx_d, ty_d;
  logic signed [SW-1:0] tx_q, ty_q;
  logic [glsg_pkg::CNT_W-1:0] steps_q, steps_d;
  // lhs tracks dy * (2*cx + sign(dx)), rhs tracks dx * (2*cy + sign(dy)).
  logic signed [AW-1:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic signed [AW-1:0] lhs_init, rhs_init;
  logic signed [AW-1:0] lhs_init_q, rhs_init_q;
  logic signed [AW-1:0] tx_ext, ty_ext;

  logic take_y;
  logic out_valid_q, out_valid_d;
  logic signed [glsg_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic last_q;

  assign tx_d   = glsg_pkg::sat_span(dx_i);
  assign ty_d   = glsg_pkg::sat_span(dy_i);
  assign tx_ext = {{(AW-SW){tx_d[SW-1]}}, tx_d};
  assign ty_ext = {{(AW-SW){ty_d[SW-1]}}, ty_d};
  assign lhs_init = tx_d[SW-1] ? -ty_ext : ty_ext;
  assign rhs_init = ty_d[SW-1] ? -tx_ext : tx_ext;

  // Midpoint test: opposite signs compare with less-than, equal signs with
  // greater-than. A vertical move always steps in y, a horizontal one in x.
  always_comb begin
    if (tx_q == '0) begin
      take_y = 1'b1;
    end else if (ty_q == '0) begin
      take_y = 1'b0;
    end else if (tx_q[SW-1] != ty_q[SW-1]) begin
      take_y = lhs_q < rhs_q;
    end else begin
      take_y = lhs_q > rhs_q;
    end
  end

  always_comb begin
    steps_d     = steps_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.load) begin
      steps_d = glsg_pkg::abs_span(tx_d) + glsg_pkg::abs_span(ty_d);
      lhs_d   = lhs_init;
      rhs_d   = rhs_init;
    end else if (cmd_i.step) begin
      steps_d     = steps_q - glsg_pkg::CNT_W'(1);
      out_valid_d = 1'b1;
      // Each unit step moves the tracked product by twice its initial value.
      if (take_y) begin
        rhs_d = rhs_q + {rhs_init_q[AW-2:0], 1'b0};
      end else begin
        lhs_d = lhs_q + {lhs_init_q[AW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q <= lhs_d;
    rhs_q <= rhs_d;
    if (cmd_i.load) begin
      tx_q       <= tx_d;
      ty_q       <= ty_d;
      lhs_init_q <= lhs_init;
      rhs_init_q <= rhs_init;
    end
    if (cmd_i.step) begin
      step_x_q <= take_y ? glsg_pkg::STEP_NONE
                         : (tx_q[SW-1] ? glsg_pkg::STEP_NEG : glsg_pkg::STEP_POS);
      step_y_q <= take_y ? (ty_q[SW-1] ? glsg_pkg::STEP_NEG : glsg_pkg::STEP_POS)
                         : glsg_pkg::STEP_NONE;
      last_q   <= (steps_q == glsg_pkg::CNT_W'(1));
    end
  end

  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.steps_last = (steps_q == glsg_pkg::CNT_W'(1));
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign step_x_o    = step_x_q;
  assign step_y_o    = step_y_q;
  assign last_step_o = last_q;

endmodule

`default_nettype wire

// File: hdl/grid_line_step_generator_unit.sv
// ----------------------------------------------------------------------------
// grid_line_step_generator_unit
// After a transfer the sequencer passes through its set-up state, then issues
// steps into the output register; a zero move returns to idle from set-up.
// The step loop emits one step per cycle while the output register has room.
// Reset: rst_ni clears the sequencer, step counter and output valid at once.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input transfer carries a relative move (dx, dy). Both spans are clamped
// to -MAX_SPAN..MAX_SPAN, then the block walks a 4-connected path from the
// origin toward the end point, one unit step per output transfer, with tlast
// marking the final step. A move of (0,0) produces no output.
//
// The choice between an x step and a y step is a half-cell midpoint test
// against the line y = (dy/dx) x. It is done exactly in integers: the two
// cross products dy*(2cx +/- 1) and dx*(2cy +/- 1) are kept in accumulators
// that move by +/- 2*dy or +/- 2*dx on each step, so no multiplier is needed.
//
// The controller owns the handshake sequencing; the datapath holds the move,
// the step counter, the accumulators and the output register. The input side
// is ready whenever no move is in progress, even while the final step of the
// previous move still waits in the output register.

module grid_line_step_generator_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Input move.
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire [15:0] s_axis_tdata_i,  // [6:0] dx, [13:7] dy, [15:14] zero
  // Output steps.
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [1:0] step_x, [3:2] step_y, [7:4] zero
  output logic       m_axis_tlast_o   // last_step
);

  glsg_pkg::glsg_cmd_t    cmd;
  glsg_pkg::glsg_status_t status;

  logic signed [glsg_pkg::SPAN_W-1:0] dx, dy;
  logic signed [glsg_pkg::STEP_W-1:0] step_x, step_y;

  assign dx = s_axis_tdata_i[glsg_pkg::SPAN_W-1:0];
  assign dy = s_axis_tdata_i[2*glsg_pkg::SPAN_W-1:glsg_pkg::SPAN_W];

  glsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glsg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .dx_i        (dx),
    .dy_i        (dy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .step_x_o    (step_x),
    .step_y_o    (step_y),
    .last_step_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, step_y, step_x};

endmodule

`default_nettype wire
